// File: rtl/sexq_pkg.sv
// ----------------------------------------------------------------------------
// sexq_pkg: shared types and constants of the sorted expiry timer queue
// Operation and status codes, request and response beats, cell control.
// ----------------------------------------------------------------------------
package sexq_pkg;

   localparam int DEPTH_DEFAULT      = 32;
   localparam int TIME_WIDTH_DEFAULT = 32;
   localparam int RESULT_LIMIT       = 32;
   localparam int CNT_WIDTH          = $clog2(RESULT_LIMIT);
   localparam int ID_WIDTH           = 8;
   localparam int FIELD_TIME_WIDTH   = 32;
   localparam int OCC_WIDTH          = 6;

   typedef enum logic [1:0] {
      FN_ADD    = 2'd0,
      FN_ADJUST = 2'd1,
      FN_DELETE = 2'd2,
      FN_TICK   = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      STS_DONE      = 3'd0,
      STS_EXPIRED   = 3'd1,
      STS_NONE      = 3'd2,
      STS_FULL      = 3'd3,
      STS_NOT_FOUND = 3'd4,
      STS_DUPLICATE = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_PLACE
   } state_type;

   typedef struct packed {
      func_type                      func;
      logic [ID_WIDTH-1:0]           timer_id;
      logic [FIELD_TIME_WIDTH-1:0]   expire;
      logic [FIELD_TIME_WIDTH-1:0]   now;
   } req_type;

   typedef struct packed {
      status_type                    status;
      logic [ID_WIDTH-1:0]           result_id;
      logic [FIELD_TIME_WIDTH-1:0]   result_expire;
      logic [OCC_WIDTH-1:0]          occupancy;
      logic                          last;
   } rsp_type;

   // per-cycle command broadcast to every cell of the chain
   typedef struct packed {
      logic insert;
      logic remove;
      logic by_id;
   } cell_ctl_type;

endpackage

// File: rtl/sorted_expiry_timer_queue_unit.sv
// Add and delete give their one result from the run state; a found adjust removes its
// entry in the run state and reports from the place state (remove, then reinsert).
// A tick's expired entries follow one per cycle, at most 32 per tick. Busy stays high
// until the last step of a command; no new request is taken while busy.
// Reset (synchronous) clears the FSM, valid bits and count; slot contents are not cleared.
// Results are strobed for one cycle; the receiver cannot stall them.
// ----------------------------------------------------------------------------
// sorted_expiry_timer_queue_unit: sorted timer list on a chain of cells
// Command FSM driving a row of slots kept in ascending expiry order.
// ----------------------------------------------------------------------------
module sorted_expiry_timer_queue_unit #(
   parameter int DEPTH      = sexq_pkg::DEPTH_DEFAULT,
   parameter int TIME_WIDTH = sexq_pkg::TIME_WIDTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  sexq_pkg::req_type req_item,
   output logic              rsp_strobe,
   output sexq_pkg::rsp_type rsp_item
);
   import sexq_pkg::*;

   localparam int FW = $clog2(DEPTH + 1);

   state_type            state_ff, state_in;
   req_type              req_ff;
   rsp_type              rsp_ff, rsp_in;
   logic                 strobe_ff, strobe_in;
   logic [FW-1:0]        fill_ff, fill_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   cell_ctl_type         ctl;

   logic [DEPTH-1:0]      valid_vec, le_vec, seen_vec, match_vec;
   logic [ID_WIDTH-1:0]   cell_id  [DEPTH];
   logic [TIME_WIDTH-1:0] cell_exp [DEPTH];

   logic [63:0]           now64, exp64, fexp64, occ64;
   logic [TIME_WIDTH-1:0] key_exp;
   logic                  found, full, tick_fin, pop;

   assign now64   = {32'd0, req_ff.now};
   assign exp64   = {32'd0, req_ff.expire};
   assign key_exp = (req_ff.func == FN_TICK) ? now64[TIME_WIDTH-1:0] : exp64[TIME_WIDTH-1:0];
   assign fexp64  = 64'(cell_exp[0]);

   assign found    = |match_vec;
   assign full     = (fill_ff == FW'(DEPTH));
   assign tick_fin = (cnt_ff == CNT_WIDTH'(RESULT_LIMIT - 1)) || !le_vec[1];
   assign pop      = ctl.remove & ~ctl.by_id;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                  lv, lle, rv, sin;
      logic [ID_WIDTH-1:0]   lid, rid;
      logic [TIME_WIDTH-1:0] lexp, rexp;

      if (i == 0) begin : g_head
         assign lv   = 1'b0;
         assign lle  = 1'b1;
         assign lid  = '0;
         assign lexp = '0;
         assign sin  = pop;
      end else begin : g_body
         assign lv   = valid_vec[i-1];
         assign lle  = le_vec[i-1];
         assign lid  = cell_id[i-1];
         assign lexp = cell_exp[i-1];
         assign sin  = seen_vec[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign rv   = 1'b0;
         assign rid  = '0;
         assign rexp = '0;
      end else begin : g_next
         assign rv   = valid_vec[i+1];
         assign rid  = cell_id[i+1];
         assign rexp = cell_exp[i+1];
      end

      sexq_cell #(
         .TIME_WIDTH (TIME_WIDTH)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .key_id      (req_ff.timer_id),
         .key_exp     (key_exp),
         .left_valid  (lv),
         .left_le     (lle),
         .left_id     (lid),
         .left_exp    (lexp),
         .right_valid (rv),
         .right_id    (rid),
         .right_exp   (rexp),
         .seen_in     (sin),
         .valid       (valid_vec[i]),
         .id          (cell_id[i]),
         .exp         (cell_exp[i]),
         .le          (le_vec[i]),
         .seen_out    (seen_vec[i]),
         .match       (match_vec[i])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_RUN;
         end
         S_RUN: begin
            if (req_ff.func == FN_ADJUST && found) begin
               state_in = S_PLACE;
            end else if (req_ff.func == FN_TICK && le_vec[0] && !tick_fin) begin
               state_in = S_RUN;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_PLACE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // outputs and chain commands
   always_comb begin
      ctl                = '0;
      strobe_in          = 1'b0;
      rsp_in             = '0;
      rsp_in.status      = STS_DONE;
      rsp_in.result_id   = req_ff.timer_id;
      rsp_in.last        = 1'b1;
      fill_in            = fill_ff;
      cnt_in             = cnt_ff;
      case (state_ff)
         S_RUN: begin
            case (req_ff.func)
               FN_ADD: begin
                  strobe_in = 1'b1;
                  if (found) begin
                     rsp_in.status = STS_DUPLICATE;
                  end else if (full) begin
                     rsp_in.status = STS_FULL;
                  end else begin
                     ctl.insert = 1'b1;
                     fill_in    = fill_ff + FW'(1);
                  end
               end
               FN_ADJUST, FN_DELETE: begin
                  if (!found) begin
                     strobe_in     = 1'b1;
                     rsp_in.status = STS_NOT_FOUND;
                  end else begin
                     ctl.remove = 1'b1;
                     ctl.by_id  = 1'b1;
                     fill_in    = fill_ff - FW'(1);
                     // adjust reports after the reinsert beat
                     strobe_in  = (req_ff.func == FN_DELETE);
                  end
               end
               FN_TICK: begin
                  strobe_in = 1'b1;
                  if (le_vec[0]) begin
                     ctl.remove           = 1'b1;
                     fill_in              = fill_ff - FW'(1);
                     rsp_in.status        = STS_EXPIRED;
                     rsp_in.result_id     = cell_id[0];
                     rsp_in.result_expire = fexp64[FIELD_TIME_WIDTH-1:0];
                     rsp_in.last          = tick_fin;
                     cnt_in               = tick_fin ? '0 : cnt_ff + CNT_WIDTH'(1);
                  end else begin
                     rsp_in.status    = STS_NONE;
                     rsp_in.result_id = '0;
                     cnt_in           = '0;
                  end
               end
               default: strobe_in = 1'b0;
            endcase
         end
         S_PLACE: begin
            ctl.insert = 1'b1;
            strobe_in  = 1'b1;
            fill_in    = fill_ff + FW'(1);
         end
         default: strobe_in = 1'b0;
      endcase
      occ64            = 64'(fill_in);
      rsp_in.occupancy = occ64[OCC_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
         fill_ff   <= '0;
         cnt_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         fill_ff   <= fill_in;
         cnt_ff    <= cnt_in;
      end
      if (start && !busy) begin
         req_ff <= req_item;
      end
      rsp_ff <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

   logic [DEPTH-2:0] ord_ok;
   for (genvar i = 0; i < DEPTH - 1; i++) begin : g_ord
      assign ord_ok[i] = !valid_vec[i+1] || (valid_vec[i] && cell_exp[i] <= cell_exp[i+1]);
   end

   assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(fill_ff))
      else $error("valid slots disagree with fill count");

   assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("timer id held in more than one slot");

   assert property (@(posedge clock) disable iff (reset)
      &ord_ok)
      else $error("slot chain out of expiry order");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.last |-> busy)
      else $error("non-final beat while idle");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PLACE |-> $past(state_ff) == S_RUN)
      else $error("reinsert step without a preceding remove");

endmodule

// File: rtl/sexq_cell.sv
// ----------------------------------------------------------------------------
// sexq_cell: one slot of the sorted timer chain
// Holds one id and expiry; keeps, loads the new entry, or takes a neighbor.
// ----------------------------------------------------------------------------
module sexq_cell #(
   parameter int TIME_WIDTH = sexq_pkg::TIME_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sexq_pkg::cell_ctl_type        ctl,
   input  logic [sexq_pkg::ID_WIDTH-1:0] key_id,
   input  logic [TIME_WIDTH-1:0]         key_exp,
   input  logic                          left_valid,
   input  logic                          left_le,
   input  logic [sexq_pkg::ID_WIDTH-1:0] left_id,
   input  logic [TIME_WIDTH-1:0]         left_exp,
   input  logic                          right_valid,
   input  logic [sexq_pkg::ID_WIDTH-1:0] right_id,
   input  logic [TIME_WIDTH-1:0]         right_exp,
   input  logic                          seen_in,
   output logic                          valid,
   output logic [sexq_pkg::ID_WIDTH-1:0] id,
   output logic [TIME_WIDTH-1:0]         exp,
   output logic                          le,
   output logic                          seen_out,
   output logic                          match
);
   import sexq_pkg::*;

   logic                  valid_ff, valid_in;
   logic [ID_WIDTH-1:0]   id_ff, id_in;
   logic [TIME_WIDTH-1:0] exp_ff, exp_in;
   logic                  take_new, take_left, take_right;

   assign match    = valid_ff && (id_ff == key_id);
   assign le       = valid_ff && (exp_ff <= key_exp);
   assign seen_out = seen_in | (ctl.by_id & match);

   // sorted chain: cells at or before the key form a prefix
   assign take_new   = ctl.insert & ~le & left_le;
   assign take_left  = ctl.insert & ~le & ~left_le;
   assign take_right = ctl.remove & seen_out;

   always_comb begin
      valid_in = valid_ff;
      id_in    = id_ff;
      exp_in   = exp_ff;
      if (take_new) begin
         valid_in = 1'b1;
         id_in    = key_id;
         exp_in   = key_exp;
      end else if (take_left) begin
         valid_in = left_valid;
         id_in    = left_id;
         exp_in   = left_exp;
      end else if (take_right) begin
         valid_in = right_valid;
         id_in    = right_id;
         exp_in   = right_exp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      id_ff  <= id_in;
      exp_ff <= exp_in;
   end

   assign valid = valid_ff;
   assign id    = id_ff;
   assign exp   = exp_ff;

endmodule
